// File: rtl/rlh_pkg.sv
// Shared types and constants for the RGB/luma histogram block.
package rlh_pkg;

    localparam int BIN_COUNT_DEF  = 256;
    localparam int COUNT_BITS_DEF = 24;
    localparam int OUT_COUNT_BITS = 24;

    localparam int S_TDATA_BITS = 32;
    localparam int S_TUSER_BITS = 2;
    localparam int M_TDATA_BITS = 112;

    localparam int STRIDE_BITS = 8;
    localparam int PIX_BITS    = 8;

    // Luma weights sum to 1 << LUMA_SHIFT
    localparam int LUMA_KR    = 218;
    localparam int LUMA_KG    = 732;
    localparam int LUMA_KB    = 74;
    localparam int LUMA_SHIFT = 10;
    localparam int LUMA_MAX   = 255;
    localparam int LUMA_SUM_BITS = 19;

    localparam int NUM_CH  = 4;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_LUMA  = 3;

    typedef enum logic [1:0] {
        MODE_PIXEL = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

endpackage

// File: rtl/rgb_luma_histogram.sv
// Top level of the RGB/luma histogram: four bin memories, stride sampling, clip flags.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+------------------------------------------
//  s_        | in        | s_tvalid/s_tready  | tuser: mode; tdata: red, green, blue, bin
//  m_        | out       | m_tvalid/m_tready  | tdata: luma, sampled, 4 counts, clip flags
//  cfg_      | in        | cfg_wr_en          | cfg_wr_data: sample_stride
//
// Every request passes through three steps: accept, memory lookup, update and result load;
// the loop through the bin memories (read, add one, write back) sets these steps.
// Reset and every clear request run a clearing pass over all BIN_COUNT rows, one row of all four
// memories per cycle, with s_tready low; a clear request loads its result first.
// A result held by m_tready low stalls the update step; a new request is taken as
// soon as the previous one has loaded its result and no clearing pass is running.
module rgb_luma_histogram #(
    parameter int BIN_COUNT  = rlh_pkg::BIN_COUNT_DEF,
    parameter int COUNT_BITS = rlh_pkg::COUNT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request: tuser[1:0] mode
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: [7:0] red, [15:8] green, [23:16] blue, [31:24] bin_index
    input  logic [rlh_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // tuser: [1:0] mode
    input  logic [rlh_pkg::S_TUSER_BITS-1:0]  s_tuser,
    // result
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: [7:0] luma, [8] sampled, [32:9] red_count, [56:33] green_count,
    //        [80:57] blue_count, [104:81] luma_count, [105] shadow_clip,
    //        [106] highlight_clip, [111:107] zero
    output logic [rlh_pkg::M_TDATA_BITS-1:0]  m_tdata,
    // configuration: sample_stride
    input  logic                              cfg_wr_en,
    input  logic [rlh_pkg::STRIDE_BITS-1:0]   cfg_wr_data
);

    localparam int ADDR_BITS = $clog2(BIN_COUNT);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int NCH = rlh_pkg::NUM_CH;
    localparam int OCB = rlh_pkg::OUT_COUNT_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_UPDATE,
        S_CLEAR
    } state_t;

    // ---------------------------------------------------------------
    // Request fields
    // ---------------------------------------------------------------
    logic [rlh_pkg::PIX_BITS-1:0] s_red, s_green, s_blue, s_bin_index;
    rlh_pkg::mode_t               s_mode;

    assign s_red       = s_tdata[7:0];
    assign s_green     = s_tdata[15:8];
    assign s_blue      = s_tdata[23:16];
    assign s_bin_index = s_tdata[31:24];
    assign s_mode      = rlh_pkg::mode_t'(s_tuser);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t                          state_reg;
    logic [rlh_pkg::STRIDE_BITS-1:0] stride_reg;
    logic [rlh_pkg::STRIDE_BITS-1:0] phase_reg;
    logic [rlh_pkg::STRIDE_BITS-1:0] phase_next;
    logic                            shadow_seen_reg;
    logic                            highlight_seen_reg;
    logic [ADDR_BITS-1:0]            clr_addr_reg;

    rlh_pkg::mode_t                  mode_reg;
    logic                            sampled_reg;
    logic                            sampled_next;
    logic [rlh_pkg::PIX_BITS-1:0]    luma_reg;
    logic [rlh_pkg::PIX_BITS-1:0]    luma_next;
    logic [ADDR_BITS-1:0]            addr_reg [NCH];

    logic                            m_valid_reg;
    logic [rlh_pkg::M_TDATA_BITS-1:0] m_data_reg;
    logic [rlh_pkg::M_TDATA_BITS-1:0] m_data_next;

    logic                            s_acc;
    logic                            commit;
    logic                            clearing;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    // Load the result once the output register is free or being emptied
    assign commit   = (state_reg == S_UPDATE) && (!m_valid_reg || m_tready);
    assign clearing = (state_reg == S_CLEAR);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------------------------------------------------------
    // Luma: weights sum to 1024, so the shifted sum already fits 8 bits;
    // cap anyway to keep the contract explicit.
    // ---------------------------------------------------------------
    logic [rlh_pkg::LUMA_SUM_BITS-1:0] luma_sum;
    logic [rlh_pkg::LUMA_SUM_BITS-1:0] luma_shifted;

    always_comb begin
        luma_sum = rlh_pkg::LUMA_SUM_BITS'(rlh_pkg::LUMA_KR)
                     * rlh_pkg::LUMA_SUM_BITS'(s_red)
                 + rlh_pkg::LUMA_SUM_BITS'(rlh_pkg::LUMA_KG)
                     * rlh_pkg::LUMA_SUM_BITS'(s_green)
                 + rlh_pkg::LUMA_SUM_BITS'(rlh_pkg::LUMA_KB)
                     * rlh_pkg::LUMA_SUM_BITS'(s_blue);
        luma_shifted = luma_sum >> rlh_pkg::LUMA_SHIFT;
        if (luma_shifted > rlh_pkg::LUMA_SUM_BITS'(rlh_pkg::LUMA_MAX)) begin
            luma_next = rlh_pkg::PIX_BITS'(rlh_pkg::LUMA_MAX);
        end else begin
            luma_next = luma_shifted[rlh_pkg::PIX_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stride phase: a pixel counts when the phase is zero; wrap once the
    // incremented phase reaches the effective stride (zero acts as one).
    // ---------------------------------------------------------------
    logic [rlh_pkg::STRIDE_BITS:0] stride_eff;
    logic [rlh_pkg::STRIDE_BITS:0] phase_inc;

    always_comb begin
        stride_eff = (stride_reg == '0) ? (rlh_pkg::STRIDE_BITS+1)'(1)
                                        : {1'b0, stride_reg};
        phase_inc  = {1'b0, phase_reg} + (rlh_pkg::STRIDE_BITS+1)'(1);
        sampled_next = (s_mode == rlh_pkg::MODE_PIXEL) && (phase_reg == '0);
        if (phase_inc >= stride_eff) begin
            phase_next = '0;
        end else begin
            phase_next = phase_inc[rlh_pkg::STRIDE_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Bin memories, one per channel; the clearing pass owns the write port
    // ---------------------------------------------------------------
    logic [COUNT_BITS-1:0] rdata  [NCH];
    logic [COUNT_BITS-1:0] wdata  [NCH];
    logic [OCB-1:0]        cnt_out [NCH];
    logic                  upd_we;
    logic                  ram_we;

    assign upd_we = commit && sampled_reg;
    assign ram_we = clearing || upd_we;

    for (genvar i = 0; i < NCH; i++) begin : g_ch
        logic [31:0] count_wide;

        rlh_ram #(
            .WIDTH (COUNT_BITS),
            .DEPTH (BIN_COUNT)
        ) u_bins (
            .clk   (aclk),
            .we    (ram_we),
            .waddr (clearing ? clr_addr_reg : addr_reg[i]),
            .wdata (clearing ? '0 : wdata[i]),
            .raddr (addr_reg[i]),
            .rdata (rdata[i])
        );

        assign wdata[i]   = (rdata[i] == COUNT_MAX) ? rdata[i]
                                                    : rdata[i] + COUNT_BITS'(1);
        assign count_wide = 32'(rdata[i]);
        assign cnt_out[i] = count_wide[OCB-1:0];
    end

    // ---------------------------------------------------------------
    // Result word
    // ---------------------------------------------------------------
    logic shadow_after;
    logic highlight_after;

    always_comb begin
        shadow_after    = shadow_seen_reg
                          || (sampled_reg && (luma_reg == '0));
        highlight_after = highlight_seen_reg
                          || (sampled_reg
                              && (luma_reg == rlh_pkg::PIX_BITS'(rlh_pkg::LUMA_MAX)));
        m_data_next = '0;
        case (mode_reg)
            rlh_pkg::MODE_PIXEL: begin
                m_data_next[7:0] = luma_reg;
                m_data_next[8]   = sampled_reg;
            end
            rlh_pkg::MODE_READ: begin
                m_data_next[32:9]   = cnt_out[rlh_pkg::CH_RED];
                m_data_next[56:33]  = cnt_out[rlh_pkg::CH_GREEN];
                m_data_next[80:57]  = cnt_out[rlh_pkg::CH_BLUE];
                m_data_next[104:81] = cnt_out[rlh_pkg::CH_LUMA];
            end
            default: begin
                m_data_next[8:0] = '0;
            end
        endcase
        m_data_next[105] = shadow_after;
        m_data_next[106] = highlight_after;
    end

    // ---------------------------------------------------------------
    // State, flags, clearing pass and captured request
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_CLEAR;
            stride_reg         <= rlh_pkg::STRIDE_BITS'(1);
            phase_reg          <= '0;
            shadow_seen_reg    <= 1'b0;
            highlight_seen_reg <= 1'b0;
            clr_addr_reg       <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                stride_reg <= cfg_wr_data;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        state_reg <= S_LOOK;
                        case (s_mode)
                            rlh_pkg::MODE_PIXEL: begin
                                phase_reg <= phase_next;
                            end
                            rlh_pkg::MODE_CLEAR: begin
                                phase_reg          <= '0;
                                shadow_seen_reg    <= 1'b0;
                                highlight_seen_reg <= 1'b0;
                            end
                            default: begin
                                phase_reg <= phase_reg;
                            end
                        endcase
                    end
                end
                S_LOOK: begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (commit) begin
                        // A clear request wipes the bins once its result is loaded
                        state_reg          <= (mode_reg == rlh_pkg::MODE_CLEAR) ? S_CLEAR
                                                                                : S_IDLE;
                        shadow_seen_reg    <= shadow_after;
                        highlight_seen_reg <= highlight_after;
                    end
                end
                S_CLEAR: begin
                    // Advance one row a cycle; wraps to zero if BIN_COUNT is a power of 2
                    clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
                    if (clr_addr_reg == ADDR_BITS'(BIN_COUNT - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end

        // Payload: hold the request while it is in flight
        if (s_acc) begin
            mode_reg    <= s_mode;
            sampled_reg <= sampled_next;
            luma_reg    <= luma_next;
            if (s_mode == rlh_pkg::MODE_READ) begin
                for (int i = 0; i < NCH; i++) begin
                    addr_reg[i] <= ADDR_BITS'(s_bin_index);
                end
            end else begin
                addr_reg[rlh_pkg::CH_RED]   <= ADDR_BITS'(s_red);
                addr_reg[rlh_pkg::CH_GREEN] <= ADDR_BITS'(s_green);
                addr_reg[rlh_pkg::CH_BLUE]  <= ADDR_BITS'(s_blue);
                addr_reg[rlh_pkg::CH_LUMA]  <= ADDR_BITS'(luma_next);
            end
        end
        if (commit) begin
            m_data_reg <= m_data_next;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_look_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> state_reg == S_LOOK)
        else $error("request accepted but lookup did not follow");

    a_update_after_look: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_LOOK |=> state_reg == S_UPDATE)
        else $error("lookup not followed by update");

    a_clear_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_mode == rlh_pkg::MODE_CLEAR) |=> !shadow_seen_reg && !highlight_seen_reg)
        else $error("clip flags survived a clear");

    a_shadow_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && sampled_reg && luma_reg == '0) |=> shadow_seen_reg)
        else $error("counted black pixel did not set shadow flag");

    a_no_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_we |-> wdata[rlh_pkg::CH_LUMA] != '0)
        else $error("bin count wrapped to zero");

endmodule

// File: rtl/rlh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rlh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
